### rtl/core/bsld_pkg.sv
// ----------------------------------------------------------------------------
// bsld_pkg
// Shared types, register codes and helper functions for the bottom sponge
// layer damping pipeline.
// ----------------------------------------------------------------------------
package bsld_pkg;

   localparam int DATA_W  = 32;
   localparam int DT_W    = 31;
   localparam int QBITS   = 34;
   localparam logic [QBITS-1:0] DELTA_CAP = 34'h2_0000_0000;
   localparam real HALF_PI = 1.57079632679489661923;

   typedef enum logic [1:0] {
      CSR_LAYER_WIDTH  = 2'd0,
      CSR_RELAX_TIME   = 2'd1,
      CSR_BOTTOM_COORD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] density;
      logic [2:0][DATA_W-1:0]   vel;
      logic [2:0][DATA_W-1:0]   incr;
      logic [DT_W-1:0]          step_size;
   } side_type;

   // round(sin^2(k*step) * 2^frac), step = pi/2 over the table size
   function automatic int prof_entry(int k, real step, int frac);
      real x;
      real s;
      x = step * real'(k);
      s = $sin(x);
      return $rtoi(s * s * (2.0 ** frac) + 0.5);
   endfunction

   function automatic logic [DATA_W-1:0] mag32(logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

endpackage

### rtl/core/bsld_index.sv
// ----------------------------------------------------------------------------
// bsld_index
// Profile index pipeline: layer depth classification, then a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsld_index #(
   parameter int ENTRIES = 1024,
   localparam int IdxW = $clog2(ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [31:0]  face_coord,
   input  logic signed [31:0]  bottom_coord,
   input  logic [30:0]         layer_width,
   output logic                out_valid,
   output logic [IdxW-1:0]     idx
);
   import bsld_pkg::*;

   localparam int DivW = 32 + IdxW;

   logic signed [33:0] n_val;
   logic               zero_w;
   logic               full_w;
   logic [DivW-1:0]    dividend;

   logic               v1_ff;
   logic [30:0]        n1_ff;
   logic               zero1_ff;
   logic               full1_ff;

   logic [IdxW:0]      v_ff;
   logic [30:0]        rem_ff  [IdxW+1];
   logic [IdxW-1:0]    quo_ff  [IdxW+1];
   logic [IdxW-1:0]    low_ff  [IdxW+1];
   logic [IdxW:0]      zero_ff;
   logic [IdxW:0]      full_ff;

   logic [31:0]        rem_sh  [IdxW];
   logic [IdxW-1:0]    ge_w;
   logic [30:0]        rem_in  [IdxW];

   logic               out_valid_ff;
   logic [IdxW-1:0]    idx_ff;

   assign n_val  = $signed({3'b000, layer_width}) - ($signed(34'(face_coord))
                   - $signed(34'(bottom_coord)));
   assign zero_w = (layer_width == '0) || (n_val <= 34'sd0);
   assign full_w = n_val >= $signed({3'b000, layer_width});
   assign dividend = DivW'(n1_ff) * DivW'(ENTRIES) + DivW'(layer_width >> 1);

   always_comb begin
      for (int k = 0; k < IdxW; k++) begin
         rem_sh[k] = {rem_ff[k], low_ff[k][IdxW-1]};
         ge_w[k]   = rem_sh[k] >= {1'b0, layer_width};
         rem_in[k] = ge_w[k] ? 31'(rem_sh[k] - {1'b0, layer_width}) : rem_sh[k][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v_ff         <= {v_ff[IdxW-1:0], v1_ff};
         out_valid_ff <= v_ff[IdxW];
      end
   end

   always_ff @(posedge clock) begin
      n1_ff      <= n_val[30:0];
      zero1_ff   <= zero_w;
      full1_ff   <= full_w;
      rem_ff[0]  <= 31'(dividend >> IdxW);
      low_ff[0]  <= dividend[IdxW-1:0];
      quo_ff[0]  <= '0;
      zero_ff[0] <= zero1_ff;
      full_ff[0] <= full1_ff;
      for (int k = 0; k < IdxW; k++) begin
         rem_ff[k+1]  <= rem_in[k];
         quo_ff[k+1]  <= {quo_ff[k][IdxW-2:0], ge_w[k]};
         low_ff[k+1]  <= low_ff[k] << 1;
         zero_ff[k+1] <= zero_ff[k];
         full_ff[k+1] <= full_ff[k];
      end
      if (zero_ff[IdxW]) begin
         idx_ff <= '0;
      end else if (full_ff[IdxW]) begin
         idx_ff <= IdxW'(ENTRIES);
      end else begin
         idx_ff <= quo_ff[IdxW];
      end
   end

   assign out_valid = out_valid_ff;
   assign idx       = idx_ff;

endmodule

### rtl/core/bsld_rom.sv
// ----------------------------------------------------------------------------
// bsld_rom
// sin^2 profile table with registered read.
// ----------------------------------------------------------------------------
module bsld_rom #(
   parameter int ENTRIES = 1024,
   parameter int FRAC = 16,
   localparam int IdxW = $clog2(ENTRIES + 1),
   localparam int SW = FRAC + 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [IdxW-1:0] idx,
   output logic            out_valid,
   output logic [SW-1:0]   scale
);
   import bsld_pkg::*;

   localparam real ProfStep = HALF_PI / real'(ENTRIES);

   logic [SW-1:0] prof_rom [ENTRIES+1];
   logic          v_ff;
   logic [SW-1:0] scale_ff;

   for (genvar k = 0; k <= ENTRIES; k++) begin : g_tab
      assign prof_rom[k] = SW'(prof_entry(k, ProfStep, FRAC));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff <= prof_rom[idx];
   end

   assign out_valid = v_ff;
   assign scale     = scale_ff;

endmodule

### rtl/core/bsld_damp.sv
// ----------------------------------------------------------------------------
// bsld_damp
// Damping term for one component: product / tau by a restoring divider,
// one quotient bit per stage, capped, then subtract or add by sign and saturate.
// ----------------------------------------------------------------------------
module bsld_damp #(
   parameter int FRAC = 16,
   localparam int PW = FRAC + 95,
   localparam int HiW = 61 - FRAC
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [PW-1:0]      prod,
   input  logic signed [31:0] incr,
   input  logic               neg,
   input  logic [30:0]        relax_time,
   output logic               out_valid,
   output logic signed [31:0] result,
   output logic               saturated
);
   import bsld_pkg::*;

   logic [HiW-1:0]     hi_w;
   logic [QBITS:0]     v_ff;
   logic [30:0]        rem_ff  [QBITS+1];
   logic [QBITS-1:0]   quo_ff  [QBITS+1];
   logic [QBITS-1:0]   low_ff  [QBITS+1];
   logic [31:0]        incr_ff [QBITS+1];
   logic [QBITS:0]     neg_ff;
   logic [QBITS:0]     cap_ff;
   logic [QBITS:0]     zero_ff;

   logic [31:0]        rem_sh  [QBITS];
   logic [QBITS-1:0]   ge_w;
   logic [30:0]        rem_in  [QBITS];

   logic [QBITS-1:0]   delta_w;
   logic signed [35:0] sum_w;

   logic               out_valid_ff;
   logic signed [31:0] result_ff;
   logic               sat_ff;

   assign hi_w = HiW'(prod >> (2 * FRAC + QBITS));

   always_comb begin
      for (int k = 0; k < QBITS; k++) begin
         rem_sh[k] = {rem_ff[k], low_ff[k][QBITS-1]};
         ge_w[k]   = rem_sh[k] >= {1'b0, relax_time};
         rem_in[k] = ge_w[k] ? 31'(rem_sh[k] - {1'b0, relax_time}) : rem_sh[k][30:0];
      end
   end

   always_comb begin
      if (zero_ff[QBITS]) begin
         delta_w = '0;
      end else if (cap_ff[QBITS] || (quo_ff[QBITS] > DELTA_CAP)) begin
         delta_w = DELTA_CAP;
      end else begin
         delta_w = quo_ff[QBITS];
      end
      if (neg_ff[QBITS]) begin
         sum_w = $signed(36'($signed(incr_ff[QBITS]))) + $signed({2'b00, delta_w});
      end else begin
         sum_w = $signed(36'($signed(incr_ff[QBITS]))) - $signed({2'b00, delta_w});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         v_ff         <= {v_ff[QBITS-1:0], in_valid};
         out_valid_ff <= v_ff[QBITS];
         sat_ff       <= v_ff[QBITS] && ((sum_w > 36'sd2147483647)
                                         || (sum_w < -36'sd2147483648));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= hi_w[30:0];
      low_ff[0]  <= prod[2*FRAC+QBITS-1 -: QBITS];
      quo_ff[0]  <= '0;
      incr_ff[0] <= incr;
      neg_ff[0]  <= neg;
      cap_ff[0]  <= hi_w >= HiW'(relax_time);
      zero_ff[0] <= relax_time == '0;
      for (int k = 0; k < QBITS; k++) begin
         rem_ff[k+1]  <= rem_in[k];
         quo_ff[k+1]  <= {quo_ff[k][QBITS-2:0], ge_w[k]};
         low_ff[k+1]  <= low_ff[k] << 1;
         incr_ff[k+1] <= incr_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         cap_ff[k+1]  <= cap_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
      if (sum_w > 36'sd2147483647) begin
         result_ff <= 32'sh7FFF_FFFF;
      end else if (sum_w < -36'sd2147483648) begin
         result_ff <= 32'sh8000_0000;
      end else begin
         result_ff <= sum_w[31:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;
   assign saturated = sat_ff;

endmodule

### rtl/core/bottom_sponge_layer_damping.sv
// ----------------------------------------------------------------------------
// bottom_sponge_layer_damping
// Sin-squared Rayleigh damping of momentum increments in a bottom sponge
// layer, one cell per clock.
// ----------------------------------------------------------------------------
// One item is taken every cycle; busy is never raised and results cannot be
// held off. Each item passes the input register, the profile index divider
// (one quotient bit per stage), the profile table read, the product
// registers and the 34-stage damping divider before its result appears.
module bottom_sponge_layer_damping #(
   parameter int PROFILE_ENTRIES = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_face_coord,
   input  logic signed [31:0] req_density,
   input  logic signed [31:0] req_vel_one,
   input  logic signed [31:0] req_vel_two,
   input  logic signed [31:0] req_vel_three,
   input  logic signed [31:0] req_incr_one,
   input  logic signed [31:0] req_incr_two,
   input  logic signed [31:0] req_incr_three,
   input  logic [30:0]        req_step_size,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_incr_one,
   output logic signed [31:0] rsp_new_incr_two,
   output logic signed [31:0] rsp_new_incr_three,
   output logic               rsp_saturated
);
   import bsld_pkg::*;

   localparam int IdxW = $clog2(PROFILE_ENTRIES + 1);
   localparam int SW = FRAC_BITS + 1;
   localparam int CW = FRAC_BITS + 32;
   localparam int CL = CW / 2;
   localparam int CH = CW - CL;
   localparam int PW = FRAC_BITS + 95;
   localparam int LI = IdxW + 3;
   localparam int DampLat = QBITS + 2;

   logic [30:0]        layer_width_ff;
   logic [30:0]        relax_time_ff;
   logic signed [31:0] bottom_coord_ff;

   logic               a_v_ff;
   logic signed [31:0] a_face_ff;
   side_type           a_side_ff;
   side_type           side_ff [LI];

   logic               idx_valid;
   logic [IdxW-1:0]    idx;
   logic               scale_valid;
   logic [SW-1:0]      scale;

   logic [62:0]        b_m_in  [3];
   logic [62:0]        b_m_ff  [3];
   logic [2:0]         b_neg_ff;
   logic [31:0]        b_incr_ff [3];
   logic [30:0]        b_dt_ff;

   logic               c_v_ff;
   logic [CW-1:0]      c_coef_ff;
   logic [62:0]        c_m_ff  [3];
   logic [2:0]         c_neg_ff;
   logic [31:0]        c_incr_ff [3];

   logic               d_v_ff;
   logic [CH+31:0]     d_pp_ff [3][4];
   logic [2:0]         d_neg_ff;
   logic [31:0]        d_incr_ff [3];

   logic               e_v_ff;
   logic [PW-1:0]      e_p_ff  [3];
   logic [2:0]         e_neg_ff;
   logic [31:0]        e_incr_ff [3];

   logic [2:0]         dmp_valid;
   logic [31:0]        dmp_result [3];
   logic [2:0]         dmp_sat;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_width_ff  <= 31'd65536;
         relax_time_ff   <= 31'd65536;
         bottom_coord_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LAYER_WIDTH:  layer_width_ff  <= csr_data[30:0];
            CSR_RELAX_TIME:   relax_time_ff   <= csr_data[30:0];
            CSR_BOTTOM_COORD: bottom_coord_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // valid bits of the input register and product stages; side data is delayed below to match the index pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start && !busy;
         c_v_ff <= scale_valid;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_face_ff           <= req_face_coord;
      a_side_ff.density   <= req_density;
      a_side_ff.vel       <= {req_vel_three, req_vel_two, req_vel_one};
      a_side_ff.incr      <= {req_incr_three, req_incr_two, req_incr_one};
      a_side_ff.step_size <= req_step_size;
      side_ff[0]          <= a_side_ff;
      for (int k = 1; k < LI; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   bsld_index #(
      .ENTRIES(PROFILE_ENTRIES)
   ) u_index (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (a_v_ff),
      .face_coord  (a_face_ff),
      .bottom_coord(bottom_coord_ff),
      .layer_width (layer_width_ff),
      .out_valid   (idx_valid),
      .idx         (idx)
   );

   bsld_rom #(
      .ENTRIES(PROFILE_ENTRIES),
      .FRAC   (FRAC_BITS)
   ) u_rom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (idx_valid),
      .idx      (idx),
      .out_valid(scale_valid),
      .scale    (scale)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         b_m_in[k] = 63'(64'(mag32(side_ff[LI-1].density))
                     * 64'(mag32($signed(side_ff[LI-1].vel[k]))));
      end
   end

   always_ff @(posedge clock) begin
      b_dt_ff <= side_ff[LI-1].step_size;
      for (int k = 0; k < 3; k++) begin
         b_m_ff[k]    <= b_m_in[k];
         b_neg_ff[k]  <= side_ff[LI-1].density[31] ^ side_ff[LI-1].vel[k][31];
         b_incr_ff[k] <= side_ff[LI-1].incr[k];
      end

      c_coef_ff <= CW'(scale) * CW'(b_dt_ff);
      c_m_ff    <= b_m_ff;
      c_neg_ff  <= b_neg_ff;
      c_incr_ff <= b_incr_ff;

      for (int k = 0; k < 3; k++) begin
         d_pp_ff[k][0] <= (CH+32)'(c_m_ff[k][31:0])  * (CH+32)'(c_coef_ff[CL-1:0]);
         d_pp_ff[k][1] <= (CH+32)'(c_m_ff[k][31:0])  * (CH+32)'(c_coef_ff[CW-1:CL]);
         d_pp_ff[k][2] <= (CH+32)'(c_m_ff[k][62:32]) * (CH+32)'(c_coef_ff[CL-1:0]);
         d_pp_ff[k][3] <= (CH+32)'(c_m_ff[k][62:32]) * (CH+32)'(c_coef_ff[CW-1:CL]);
      end
      d_neg_ff  <= c_neg_ff;
      d_incr_ff <= c_incr_ff;

      for (int k = 0; k < 3; k++) begin
         e_p_ff[k] <= PW'(d_pp_ff[k][0]) + (PW'(d_pp_ff[k][1]) << CL)
                      + (PW'(d_pp_ff[k][2]) << 32) + (PW'(d_pp_ff[k][3]) << (32 + CL));
      end
      e_neg_ff  <= d_neg_ff;
      e_incr_ff <= d_incr_ff;
   end

   for (genvar g = 0; g < 3; g++) begin : g_damp
      bsld_damp #(
         .FRAC(FRAC_BITS)
      ) u_damp (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (e_v_ff),
         .prod      (e_p_ff[g]),
         .incr      ($signed(e_incr_ff[g])),
         .neg       (e_neg_ff[g]),
         .relax_time(relax_time_ff),
         .out_valid (dmp_valid[g]),
         .result    (dmp_result[g]),
         .saturated (dmp_sat[g])
      );
   end

   assign rsp_valid          = dmp_valid[0];
   assign rsp_new_incr_one   = $signed(dmp_result[0]);
   assign rsp_new_incr_two   = $signed(dmp_result[1]);
   assign rsp_new_incr_three = $signed(dmp_result[2]);
   assign rsp_saturated      = |dmp_sat;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_valid |-> (idx <= IdxW'(PROFILE_ENTRIES)))
      else $error("profile index out of range");

   a_idx_lat: assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> ##LI idx_valid)
      else $error("index pipeline lost an item");

   a_damp_lat: assert property (@(posedge clock) disable iff (reset)
      e_v_ff |-> ##DampLat rsp_valid)
      else $error("damping pipeline lost an item");

   a_sat_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_saturated)
      else $error("saturation flag without a result");

endmodule

### tb/sv/bottom_sponge_layer_damping_test.sv
// ----------------------------------------------------------------------------
// bottom_sponge_layer_damping_test
// Streams cells through the sponge layer damper under several register
// settings, with random gaps between items, and compares each result with an
// exact fixed-point prediction of the damped momentum increments.
// ----------------------------------------------------------------------------
module bottom_sponge_layer_damping_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bsld_pkg::*;

   localparam int ENTRIES = 1024;
   localparam int FBITS = 16;
   localparam int SETTLE = 70;
   localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

   typedef struct {
      logic signed [31:0] face;
      logic signed [31:0] rho;
      logic signed [31:0] vel [3];
      logic signed [31:0] inc [3];
      logic [30:0]        dt;
   } cell_type;

   typedef struct {
      logic signed [31:0] inc [3];
      logic               sat;
   } damped_type;

   logic clock, reset, start, busy;
   logic signed [31:0] req_face_coord, req_density, req_vel_one, req_vel_two, req_vel_three;
   logic signed [31:0] req_incr_one, req_incr_two, req_incr_three;
   logic [30:0] req_step_size;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;
   logic rsp_valid, rsp_saturated;
   logic signed [31:0] rsp_new_incr_one, rsp_new_incr_two, rsp_new_incr_three;

   bottom_sponge_layer_damping dut (.*);

   logic [31:0] sponge_profile [ENTRIES+1];
   logic [30:0] width_q, tau_q;
   logic signed [31:0] bottom_q;

   cell_type   pending_cells [$];
   damped_type expected_incrs [$];
   int         mismatches;
   int         gap_left;

   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[125:62];
   endfunction

   function automatic logic [63:0] sin_q62(logic [63:0] x);
      logic [63:0] x2, term, sum;
      x2 = mul_q62(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 30; n++) begin
         term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
         if (n & 1) sum = sum - term;
         else sum = sum + term;
      end
      return sum;
   endfunction

   function automatic logic [31:0] damped_incr(logic signed [31:0] incr, logic signed [31:0] rho,
                                               logic signed [31:0] vel, logic [63:0] coef,
                                               ref logic sat);
      logic neg;
      logic [63:0] m, delta;
      logic [127:0] p;
      logic signed [63:0] res;
      neg = rho[31] != vel[31];
      m = (rho[31] ? -64'(rho) : 64'(rho)) * (vel[31] ? -64'(vel) : 64'(vel));
      p = (128'(m) * 128'(coef)) >> (2 * FBITS);
      if (tau_q == 0) delta = 0;
      else if ((p >> 64) >= 128'(tau_q)) delta = 64'(DELTA_CAP);
      else begin
         delta = 64'(p / 128'(tau_q));
         if (delta > 64'(DELTA_CAP)) delta = 64'(DELTA_CAP);
      end
      res = neg ? 64'(incr) + signed'(delta) : 64'(incr) - signed'(delta);
      if (res > 64'sh7FFFFFFF) begin
         res = 64'sh7FFFFFFF;
         sat = 1;
      end else if (res < -64'sh80000000) begin
         res = -64'sh80000000;
         sat = 1;
      end
      return res[31:0];
   endfunction

   function automatic damped_type predict_damping(cell_type c);
      damped_type r;
      logic signed [63:0] n;
      logic [63:0] idx, coef;
      logic sat;
      sat = 0;
      if (width_q == 0) idx = 0;
      else begin
         n = 64'(width_q) - (64'(c.face) - 64'(bottom_q));
         if (n <= 0) idx = 0;
         else if (n >= 64'(width_q)) idx = ENTRIES;
         else idx = (64'(n) * ENTRIES + 64'(width_q / 2)) / 64'(width_q);
      end
      coef = 64'(sponge_profile[idx]) * 64'(c.dt);
      for (int i = 0; i < 3; i++) r.inc[i] = damped_incr(c.inc[i], c.rho, c.vel[i], coef, sat);
      r.sat = sat;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         gap_left <= 0;
      end else begin
         logic nxt;
         cell_type c;
         if (start && !busy) begin
            c.face = req_face_coord;
            c.rho = req_density;
            c.vel[0] = req_vel_one; c.vel[1] = req_vel_two; c.vel[2] = req_vel_three;
            c.inc[0] = req_incr_one; c.inc[1] = req_incr_two; c.inc[2] = req_incr_three;
            c.dt = req_step_size;
            expected_incrs.push_back(predict_damping(c));
         end
         if (!start || !busy) begin
            nxt = 0;
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (pending_cells.size() > 0) begin
               c = pending_cells.pop_front();
               req_face_coord <= c.face;
               req_density <= c.rho;
               req_vel_one <= c.vel[0]; req_vel_two <= c.vel[1]; req_vel_three <= c.vel[2];
               req_incr_one <= c.inc[0]; req_incr_two <= c.inc[1]; req_incr_three <= c.inc[2];
               req_step_size <= c.dt;
               nxt = 1;
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            end
            start <= nxt;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         damped_type e;
         if (expected_incrs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h %h %h sat %b", rsp_new_incr_one,
                                           rsp_new_incr_two, rsp_new_incr_three, rsp_saturated);
         end else begin
            e = expected_incrs.pop_front();
            if (e.inc[0] !== rsp_new_incr_one || e.inc[1] !== rsp_new_incr_two ||
                e.inc[2] !== rsp_new_incr_three || e.sat !== rsp_saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h sat %b, got %h %h %h sat %b",
                           e.inc[0], e.inc[1], e.inc[2], e.sat, rsp_new_incr_one,
                           rsp_new_incr_two, rsp_new_incr_three, rsp_saturated);
            end
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_LAYER_WIDTH: width_q = value[30:0];
         CSR_RELAX_TIME: tau_q = value[30:0];
         default: bottom_q = value;
      endcase
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_cells.size() != 0 || start || expected_incrs.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic cell_type random_cell();
      cell_type c;
      logic signed [63:0] f;
      if ($urandom_range(0, 4) == 0) c.face = $urandom();
      else begin
         f = 64'(bottom_q) + $signed(64'($urandom_range(0, 3 * 32'(width_q) / 1)))
             - 64'(width_q);
         c.face = f[31:0];
      end
      c.rho = pick_value();
      for (int i = 0; i < 3; i++) begin
         c.vel[i] = pick_value();
         c.inc[i] = pick_value();
      end
      case ($urandom_range(0, 3))
         0: c.dt = 31'($urandom());
         1: c.dt = $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'd0;
         default: c.dt = 31'($urandom_range(0, 1 << 17));
      endcase
      return c;
   endfunction

   function automatic cell_type make_cell(logic [31:0] face, logic [31:0] rho, logic [31:0] v,
                                          logic [31:0] inc, logic [30:0] dt);
      cell_type c;
      c.face = face;
      c.rho = rho;
      for (int i = 0; i < 3; i++) begin
         c.vel[i] = v ^ (i << 3);
         c.inc[i] = inc;
      end
      c.dt = dt;
      return c;
   endfunction

   initial begin
      logic [63:0] q, r, x, s2;
      logic [31:0] settings [9][3];
      q = PI_HALF_Q62 / ENTRIES;
      r = PI_HALF_Q62 % ENTRIES;
      for (int k = 0; k <= ENTRIES; k++) begin
         x = q * k + (r * k) / ENTRIES;
         s2 = mul_q62(sin_q62(x), sin_q62(x));
         sponge_profile[k] = 32'((s2 + (64'd1 << (61 - FBITS))) >> (62 - FBITS));
      end
      width_q = 31'd65536; tau_q = 31'd65536; bottom_q = 0;
      mismatches = 0;
      reset = 1;
      csr_valid = 0; csr_index = CSR_LAYER_WIDTH; csr_data = 0;
      req_face_coord = 0; req_density = 0; req_vel_one = 0; req_vel_two = 0;
      req_vel_three = 0; req_incr_one = 0; req_incr_two = 0; req_incr_three = 0;
      req_step_size = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: extremes, above/below/inside the layer, zero step
      pending_cells.push_back(make_cell(32'h0, 32'h10000, 32'h10000, 32'h10000, 31'h10000));
      pending_cells.push_back(make_cell(32'h8000, 32'h10000, 32'h20000, 32'h0, 31'h10000));
      pending_cells.push_back(make_cell(32'h20000, 32'h10000, 32'h10000, 32'h5, 31'h10000));
      pending_cells.push_back(make_cell(32'h10000, 32'h10000, 32'h10000, 32'h5, 31'h10000));
      pending_cells.push_back(make_cell(32'hFFFF0000, 32'hFFFF0000, 32'h10000, 32'h0, 31'h8000));
      pending_cells.push_back(make_cell(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h80000000, 31'h7FFFFFFF));
      pending_cells.push_back(make_cell(32'h80000000, 32'h80000000, 32'h80000000,
                                        32'h7FFFFFFF, 31'h7FFFFFFF));
      pending_cells.push_back(make_cell(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                        32'h80000000, 31'h7FFFFFFF));
      pending_cells.push_back(make_cell(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 31'h7FFFFFFF));
      pending_cells.push_back(make_cell(32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1234, 31'h0));
      pending_cells.push_back(make_cell(32'h0, 32'h0, 32'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF));
      pending_cells.push_back(make_cell(32'h7FFF, 32'h10000, 32'h10000, 32'h0, 31'h10000));
      pending_cells.push_back(make_cell(32'h8000, 32'hFFFF8000, 32'h30000, 32'h0, 31'h10000));
      pending_cells.push_back(make_cell(32'h0, 32'h40000000, 32'hC0000000, 32'h7FFFFFF0,
                                        31'h10000));
      repeat (160) pending_cells.push_back(random_cell());
      drain();

      settings = '{'{32'h00010000, 32'h00010000, 32'h0},
                   '{32'h00000001, 32'h00000001, 32'h80000000},
                   '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF},
                   '{32'h80000000, 32'h00000001, 32'h0},
                   '{32'h00000001, 32'h80000000, 32'h00010000},
                   '{32'h00100000, 32'h00004000, 32'hFFF00000},
                   '{32'h00000400, 32'h00200000, 32'h00000000},
                   '{32'h01000000, 32'h00010000, 32'h12345678},
                   '{32'h00030000, 32'h00008000, 32'hFFFF0000}};
      foreach (settings[p]) begin
         write_csr(CSR_LAYER_WIDTH, settings[p][0]);
         write_csr(CSR_RELAX_TIME, settings[p][1]);
         write_csr(CSR_BOTTOM_COORD, settings[p][2]);
         repeat (140) pending_cells.push_back(random_cell());
         drain();
      end

      if (mismatches == 0) $display("bottom_sponge_layer_damping verification clean");
      else $display("bottom_sponge_layer_damping verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("bottom_sponge_layer_damping verification failed");
      $finish;
   end

endmodule
